// File: rtl/core/tcled_pkg.sv
// Shared constants for the text-command LED mode controller.
// Depends on nothing; imported by the controller and its checker.
package tcled_pkg;

	localparam int LINE_BUFFER_SIZE = 16;
	localparam int LINE_CAPACITY    = LINE_BUFFER_SIZE - 1;
	localparam int LEN_W            = $clog2(LINE_BUFFER_SIZE);
	localparam int IDX_W            = $clog2(LINE_CAPACITY);

	localparam int PERIOD_W = 16;
	localparam logic [PERIOD_W-1:0] BLINK_PERIOD_RESET = 16'd500;

	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	localparam logic [1:0] LEDM_OFF   = 2'd0;
	localparam logic [1:0] LEDM_ON    = 2'd1;
	localparam logic [1:0] LEDM_BLINK = 2'd2;

	localparam logic [2:0] REPORT_NONE    = 3'd0;
	localparam logic [2:0] REPORT_ON      = 3'd1;
	localparam logic [2:0] REPORT_OFF     = 3'd2;
	localparam logic [2:0] REPORT_BLINK   = 3'd3;
	localparam logic [2:0] REPORT_UNKNOWN = 3'd4;

	localparam logic [7:0] CHAR_CR    = 8'd13;
	localparam logic [7:0] CHAR_LF    = 8'd10;
	localparam logic [7:0] CHAR_NUL   = 8'd0;
	localparam logic [7:0] CHAR_LOW_A = 8'h61;
	localparam logic [7:0] CHAR_LOW_Z = 8'h7A;
	localparam logic [7:0] CASE_SHIFT = 8'd32;
	localparam logic [7:0] CHAR_B     = 8'h42;
	localparam logic [7:0] CHAR_F     = 8'h46;
	localparam logic [7:0] CHAR_I     = 8'h49;
	localparam logic [7:0] CHAR_K     = 8'h4B;
	localparam logic [7:0] CHAR_L     = 8'h4C;
	localparam logic [7:0] CHAR_N     = 8'h4E;
	localparam logic [7:0] CHAR_O     = 8'h4F;

endpackage

// File: rtl/core/text_command_led_mode_controller.sv
// Text-command LED mode controller: line buffer, command match and blink timer.
// Depends on tcled_pkg.
//
// Usage: the input channel (in_valid, in_stall, command, rx_byte) carries one
// transaction per serial byte or per millisecond tick. Each accepted
// transaction gives exactly one result on the output channel (out_valid,
// out_stall, led_pin, led_mode, report) in the order of arrival.
// The item is held in an input register, then the line compare and timer
// update run in one short combinational pass and the result is registered.
// Throughput is one item per cycle while the receiver does not stall, set by
// that single pass through the state update.
// When the receiver stalls, the result register holds and the input register
// takes one more item; in_stall rises only when both are full.
// The configuration channel (cfg_valid, cfg_ready, blink_period) is always
// ready; the user must write it only while the block is idle (not enforced).
// Reset puts the block in blink mode with the pin low, the countdown and the
// period at 500 ticks and the line empty. The line store itself is not reset;
// only entries written since the last end of line are ever compared.
module text_command_led_mode_controller (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           command,
	input  logic [7:0]                     rx_byte,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           led_pin,
	output logic [1:0]                     led_mode,
	output logic [2:0]                     report,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [tcled_pkg::PERIOD_W-1:0] blink_period
);
	import tcled_pkg::*;

	logic                valid_s1;
	logic                command_s1;
	logic [7:0]          byte_s1;

	logic [PERIOD_W-1:0] period_q;
	logic [1:0]          mode_q;
	logic                blink_level_q;
	logic                pin_level_q;
	logic [PERIOD_W-1:0] countdown_q;
	logic [LEN_W-1:0]    line_len_q;
	logic [7:0]          line_store_q [LINE_CAPACITY];

	logic                out_valid_q;
	logic                out_pin_q;
	logic [1:0]          out_mode_q;
	logic [2:0]          out_report_q;

	logic                advance;
	logic                is_eol;
	logic                store_char;
	logic [7:0]          upper_char;
	logic                match_on, match_off, match_blink, line_nonempty;

	logic [1:0]          mode_d;
	logic                blink_level_d;
	logic                pin_level_d;
	logic [PERIOD_W-1:0] countdown_d;
	logic [LEN_W-1:0]    line_len_d;
	logic [2:0]          report_d;

	assign advance   = !out_valid_q || !out_stall;
	assign in_stall  = valid_s1 && !advance;
	assign cfg_ready = 1'b1;

	assign out_valid = out_valid_q;
	assign led_pin   = out_pin_q;
	assign led_mode  = out_mode_q;
	assign report    = out_report_q;

	assign is_eol     = (command_s1 == CMD_BYTE) && (byte_s1 == CHAR_CR || byte_s1 == CHAR_LF);
	assign store_char = (command_s1 == CMD_BYTE) && !is_eol
		&& (line_len_q < LEN_W'(LINE_CAPACITY));
	assign upper_char = (byte_s1 >= CHAR_LOW_A && byte_s1 <= CHAR_LOW_Z)
		? byte_s1 - CASE_SHIFT : byte_s1;

	// A word matches when its letters lead the line and the text ends right after
	// them, either at the line's end or at a zero byte.
	always_comb begin
		match_on = (line_len_q >= LEN_W'(2))
			&& line_store_q[0] == CHAR_O && line_store_q[1] == CHAR_N
			&& (line_len_q == LEN_W'(2) || line_store_q[2] == CHAR_NUL);
		match_off = (line_len_q >= LEN_W'(3))
			&& line_store_q[0] == CHAR_O && line_store_q[1] == CHAR_F
			&& line_store_q[2] == CHAR_F
			&& (line_len_q == LEN_W'(3) || line_store_q[3] == CHAR_NUL);
		match_blink = (line_len_q >= LEN_W'(5))
			&& line_store_q[0] == CHAR_B && line_store_q[1] == CHAR_L
			&& line_store_q[2] == CHAR_I && line_store_q[3] == CHAR_N
			&& line_store_q[4] == CHAR_K
			&& (line_len_q == LEN_W'(5) || line_store_q[5] == CHAR_NUL);
		line_nonempty = (line_len_q != '0) && (line_store_q[0] != CHAR_NUL);
	end

	always_comb begin
		mode_d        = mode_q;
		blink_level_d = blink_level_q;
		pin_level_d   = pin_level_q;
		countdown_d   = countdown_q;
		line_len_d    = line_len_q;
		report_d      = REPORT_NONE;
		if (command_s1 == CMD_TICK) begin
			if (mode_q == LEDM_BLINK) begin
				if (countdown_q <= PERIOD_W'(1)) begin
					blink_level_d = !blink_level_q;
					pin_level_d   = !blink_level_q;
					countdown_d   = period_q;
				end else begin
					countdown_d = countdown_q - PERIOD_W'(1);
				end
			end
		end else if (is_eol) begin
			if (line_len_q != '0) begin
				line_len_d = '0;
				if (match_on) begin
					mode_d      = LEDM_ON;
					pin_level_d = 1'b1;
					report_d    = REPORT_ON;
				end else if (match_off) begin
					mode_d      = LEDM_OFF;
					pin_level_d = 1'b0;
					report_d    = REPORT_OFF;
				end else if (match_blink) begin
					mode_d      = LEDM_BLINK;
					countdown_d = period_q;
					report_d    = REPORT_BLINK;
				end else if (line_nonempty) begin
					report_d = REPORT_UNKNOWN;
				end
			end
		end else if (store_char) begin
			line_len_d = line_len_q + LEN_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			out_valid_q   <= 1'b0;
			period_q      <= BLINK_PERIOD_RESET;
			mode_q        <= LEDM_BLINK;
			blink_level_q <= 1'b0;
			pin_level_q   <= 1'b0;
			countdown_q   <= BLINK_PERIOD_RESET;
			line_len_q    <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				period_q <= blink_period;
			end
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
			end
			if (valid_s1 && advance) begin
				mode_q        <= mode_d;
				blink_level_q <= blink_level_d;
				pin_level_q   <= pin_level_d;
				countdown_q   <= countdown_d;
				line_len_q    <= line_len_d;
			end
		end
	end

	// Payload registers carry no reset.
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			command_s1 <= command;
			byte_s1    <= rx_byte;
		end
		if (valid_s1 && advance) begin
			out_pin_q    <= pin_level_d;
			out_mode_q   <= mode_d;
			out_report_q <= report_d;
			if (store_char) begin
				line_store_q[line_len_q[IDX_W-1:0]] <= upper_char;
			end
		end
	end

endmodule

// File: rtl/core/tcled_checker.sv
// Port-level checker for the text-command LED mode controller, with its bind.
// Depends on tcled_pkg and on text_command_led_mode_controller.
module tcled_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic       led_pin,
	input logic [1:0] led_mode,
	input logic [2:0] report
);
	import tcled_pkg::*;

	// A result held back by the receiver must not change.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable({led_pin, led_mode, report}))
		else $error("result changed while stalled");

	// Steady modes fix the pin level.
	a_mode_pin: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (led_mode == LEDM_ON || led_mode == LEDM_OFF)
		|-> led_pin == (led_mode == LEDM_ON))
		else $error("pin level disagrees with mode");

	// A command report matches the mode it sets.
	a_report_mode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && report != REPORT_NONE && report != REPORT_UNKNOWN
		|-> (report == REPORT_ON && led_mode == LEDM_ON)
		 || (report == REPORT_OFF && led_mode == LEDM_OFF)
		 || (report == REPORT_BLINK && led_mode == LEDM_BLINK))
		else $error("report disagrees with mode");

	// The input side can only stall when a result is waiting on a stalled receiver.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled while output free");

endmodule

bind text_command_led_mode_controller tcled_checker u_tcled_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.led_pin     (led_pin),
	.led_mode    (led_mode),
	.report      (report)
);
